// ===== hdl/ntv_pkg.sv =====
// Package for the numeric text validator: character codes, number modes,
// scan phases, the item type shared by both modules and the scan state type.
// No dependencies.
package ntv_pkg;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_E = 8'h65;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;

   // number modes
   localparam logic [1:0] MODE_UNSIGNED = 2'd0;
   localparam logic [1:0] MODE_SIGNED   = 2'd1;
   localparam logic [1:0] MODE_FLOAT    = 2'd2;

   // float scan phases
   localparam logic [2:0] PHASE_INTEGER    = 3'd0;
   localparam logic [2:0] PHASE_FRACTION   = 3'd1;
   localparam logic [2:0] PHASE_EXP_START  = 3'd2;
   localparam logic [2:0] PHASE_EXP_DIGITS = 3'd3;

   // one input item
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_string;
   } item_type;

   // per-string scan state
   typedef struct packed {
      logic       at_first_char;
      logic [2:0] phase;
      logic       mantissa_seen;
      logic       fraction_seen;
      logic       exponent_seen;
      logic       locked;
      logic       locked_value;
   } scan_state_type;

   localparam scan_state_type SCAN_CLEAR = '{
      at_first_char: 1'b1,
      phase:         PHASE_INTEGER,
      mantissa_seen: 1'b0,
      fraction_seen: 1'b0,
      exponent_seen: 1'b0,
      locked:        1'b0,
      locked_value:  1'b0
   };

endpackage

// ===== hdl/ntv_item_if.sv =====
// Valid/ready channel interfaces for the numeric text validator:
// the character item channel and the verdict channel.
// No dependencies.
interface ntv_item_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_string;

   modport source (output valid, output char_code, output end_of_string, input ready);
   modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface ntv_result_if;
   logic valid;
   logic ready;
   logic is_valid;

   modport source (output valid, output is_valid, input ready);
   modport sink   (input valid, input is_valid, output ready);
endinterface

// ===== hdl/numeric_text_validator.sv =====
// Numeric text validator.
// The req_if channel carries one character per item (char_code, end_of_string);
// the string is judged as unsigned integer, signed integer or float with
// exponent, by the mode in the csr_ register (0, 1, 2; 3 acts as float).
// A NUL ends the string early; characters after a NUL or a rejection are
// ignored until the end mark. Only the item with end_of_string set gives a
// result item on rsp_if, with is_valid set when the string is a valid number.
// A verdict reaches rsp_if through the input register, then the result register,
// once its end item is taken. Throughput: one item per cycle while the receiver
// does not leave a waiting result untaken in front of a held end item.
// When the receiver stalls, the pending result holds, the input register keeps
// one more item, and req_if.ready drops only if that item is an end item.
// Items without end mark keep flowing while a result waits.
// Reset (synchronous) empties both registers, clears the string state and
// sets the mode to float. Write the mode only while the block is idle.
// Depends on ntv_pkg, ntv_item_if, ntv_result_if and ntv_scan.
module numeric_text_validator
   import ntv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ntv_item_if.sink            req_if,
   ntv_result_if.source        rsp_if,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_write_data
);

   logic [1:0] mode_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_value_ff;
   logic       advance;
   logic       verdict;

   // the held item moves on unless it is an end item facing a full result slot that the receiver does not take
   assign advance = in_valid_ff
                    && (!in_item_ff.end_of_string || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_if.valid || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_item_ff.end_of_string)
                         || (rsp_valid_ff && !rsp_if.ready);

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FLOAT;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_if.valid && req_if.ready) begin
         in_item_ff.char_code     <= req_if.char_code;
         in_item_ff.end_of_string <= req_if.end_of_string;
      end
   end

   ntv_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_item_ff),
      .number_mode (mode_ff),
      .verdict     (verdict)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_item_ff.end_of_string) begin
         rsp_value_ff <= verdict;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.is_valid = rsp_value_ff;

`ifndef SYNTHESIS
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("held input item lost or changed");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_item_ff.end_of_string))
      else $error("result without an end item");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_item_ff.end_of_string && rsp_valid_ff && !rsp_if.ready
      |-> !advance)
      else $error("end item advanced over a waiting result");
`endif

endmodule

// ===== hdl/ntv_scan.sv =====
// Per-string scan state and the character classification logic.
// Depends on ntv_pkg.
module ntv_scan
   import ntv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  logic [1:0] number_mode,
   output logic       verdict
);

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type taken;

   logic is_digit;
   logic is_minus;
   logic is_exp;
   logic any_mant;
   logic [2:0] ph;

   assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
   assign is_minus = (item.char_code == CHAR_MINUS);
   assign is_exp   = (item.char_code == CHAR_LOW_E) || (item.char_code == CHAR_UP_E);
   assign any_mant = state_ff.mantissa_seen | state_ff.fraction_seen;

   // state after the character is taken
   always_comb begin
      taken = state_ff;
      ph    = state_ff.phase;
      if (!state_ff.locked) begin
         taken.at_first_char = 1'b0;
         if (number_mode == MODE_UNSIGNED || number_mode == MODE_SIGNED) begin
            if (number_mode == MODE_SIGNED && state_ff.at_first_char && is_minus) begin
               taken.locked = 1'b0;
            end else if (is_digit) begin
               taken.mantissa_seen = 1'b1;
            end else begin
               taken.locked       = 1'b1;
               taken.locked_value = (item.char_code == CHAR_NUL) & state_ff.mantissa_seen;
            end
         end else if (!(state_ff.at_first_char && is_minus)) begin
            // a minus may open the exponent
            if (ph == PHASE_EXP_START) begin
               ph          = PHASE_EXP_DIGITS;
               taken.phase = PHASE_EXP_DIGITS;
            end
            if (!(state_ff.phase == PHASE_EXP_START && is_minus)) begin
               unique case (ph)
                  PHASE_INTEGER: begin
                     if (is_digit) begin
                        taken.mantissa_seen = 1'b1;
                     end else if (item.char_code == CHAR_NUL) begin
                        taken.locked       = 1'b1;
                        taken.locked_value = state_ff.mantissa_seen;
                     end else if (item.char_code == CHAR_DOT) begin
                        taken.phase = PHASE_FRACTION;
                     end else if (is_exp && state_ff.mantissa_seen) begin
                        taken.phase = PHASE_EXP_START;
                     end else begin
                        taken.locked       = 1'b1;
                        taken.locked_value = 1'b0;
                     end
                  end
                  PHASE_FRACTION: begin
                     if (is_digit) begin
                        taken.fraction_seen = 1'b1;
                     end else if (item.char_code == CHAR_NUL) begin
                        taken.locked       = 1'b1;
                        taken.locked_value = any_mant;
                     end else if (is_exp && any_mant) begin
                        taken.phase = PHASE_EXP_START;
                     end else begin
                        taken.locked       = 1'b1;
                        taken.locked_value = 1'b0;
                     end
                  end
                  PHASE_EXP_DIGITS: begin
                     if (is_digit) begin
                        taken.exponent_seen = 1'b1;
                     end else begin
                        taken.locked       = 1'b1;
                        taken.locked_value = (item.char_code == CHAR_NUL)
                                             & state_ff.exponent_seen & any_mant;
                     end
                  end
                  default: begin
                     taken.locked       = 1'b1;
                     taken.locked_value = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   // verdict on the end item
   always_comb begin
      if (taken.locked) begin
         verdict = taken.locked_value;
      end else if (number_mode == MODE_UNSIGNED || number_mode == MODE_SIGNED) begin
         verdict = taken.mantissa_seen;
      end else if (taken.phase == PHASE_INTEGER) begin
         verdict = taken.mantissa_seen;
      end else if (taken.phase == PHASE_FRACTION) begin
         verdict = taken.mantissa_seen | taken.fraction_seen;
      end else begin
         verdict = taken.exponent_seen & (taken.mantissa_seen | taken.fraction_seen);
      end
   end

   // next state: string state clears after the end item
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = item.end_of_string ? SCAN_CLEAR : taken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      advance && item.end_of_string |=> state_ff.at_first_char && !state_ff.locked
                                          && state_ff.phase == PHASE_INTEGER)
      else $error("scan state not cleared after end item");

   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff.locked && !(advance && item.end_of_string)
      |=> state_ff.locked && $stable(state_ff.locked_value))
      else $error("locked verdict changed within a string");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PHASE_INTEGER || state_ff.phase == PHASE_FRACTION
      || state_ff.phase == PHASE_EXP_START || state_ff.phase == PHASE_EXP_DIGITS)
      else $error("scan phase out of range");
`endif

endmodule
